[sv/mbt_pkg.sv]
// Package for the mobility binding table: command codes, routes, queue
// and table entry types shared by the front end, queue and table engine.
// No dependencies.
package mbt_pkg;

    // Input kind codes
    localparam logic [2:0] KIND_REQUEST = 3'd0;
    localparam logic [2:0] KIND_REPLY   = 3'd1;
    localparam logic [2:0] KIND_PLAIN   = 3'd2;
    localparam logic [2:0] KIND_ENCAP   = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    // Route codes of a result
    localparam logic [2:0] ROUTE_REQUEST   = 3'd0;
    localparam logic [2:0] ROUTE_REPLY     = 3'd1;
    localparam logic [2:0] ROUTE_TUNNEL    = 3'd2;
    localparam logic [2:0] ROUTE_NO_TUNNEL = 3'd3;
    localparam logic [2:0] ROUTE_REWRITTEN = 3'd4;
    localparam logic [2:0] ROUTE_DROPPED   = 3'd5;
    localparam logic [2:0] ROUTE_TICK      = 3'd6;

    localparam logic [7:0]  PROTO_UDP         = 8'd17;
    localparam logic [15:0] PORT_REGISTRATION = 16'd434;
    localparam logic [7:0]  REPLY_ACCEPTED    = 8'd1;

    // Command queue between front end and table engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [2:0] {
        OP_REQ,
        OP_REPLY_DEL,
        OP_REPLY_KEEP,
        OP_PLAIN,
        OP_ENCAP,
        OP_TICK,
        OP_DROP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
        logic [31:0] care_of;
        logic [15:0] life;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [31:0] home;
        logic [31:0] care_of;
        logic [15:0] remaining;
    } t_entry;

endpackage

[sv/mobility_binding_table_core.sv]
// Top level of the home-agent mobility binding table.
// Depends on mbt_pkg, mbt_front, mbt_cmd_fifo and mbt_engine.
//
// Channel   | Ports                                         | Transfer
// ----------+-----------------------------------------------+------------------------
// command   | start, busy, i_kind .. i_udp_dest_port        | start && !busy at edge
// result    | o_valid, o_route, o_outer_*, o_table_full     | o_valid, one cycle
//
// Table pass: an item that touches the table (registration request, denied
// reply, plain or encapsulated packet, tick) makes the engine walk every
// entry, then take an insert step for a registration that is stored; the binding
// memory is read one entry per cycle. Other items go straight to the finish state.
// Reset: synchronous, active low; afterwards the engine clears the table
// entry by entry, during which busy is high.
// Stalls: busy rises only when the command queue is full or while clearing;
// the receiver cannot stall, so results leave as soon as they are formed.
module mobility_binding_table_core
    import mbt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_lookup_address,
    input  logic [31:0] i_care_of_address,
    input  logic [15:0] i_lifetime,
    input  logic [7:0]  i_reply_code,
    input  logic [7:0]  i_ip_protocol,
    input  logic [15:0] i_udp_dest_port,
    output logic        o_valid,
    output logic [2:0]  o_route,
    output logic [31:0] o_outer_destination,
    output logic [31:0] o_outer_source,
    output logic        o_table_full
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_empty;
    t_cmd q_head;
    logic pop;
    logic clearing;

    // Hold off new commands while the queue is full or the table clears
    assign busy = q_full || clearing;

    // Classify the command and hand it to the queue
    mbt_front u_front (
        .i_start           (start),
        .i_ready           (!busy),
        .i_kind            (i_kind),
        .i_lookup_address  (i_lookup_address),
        .i_care_of_address (i_care_of_address),
        .i_lifetime        (i_lifetime),
        .i_reply_code      (i_reply_code),
        .i_ip_protocol     (i_ip_protocol),
        .i_udp_dest_port   (i_udp_dest_port),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    // Decouple acceptance from the table pass
    mbt_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Walk the table for each command that needs it and drive the result
    mbt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (q_empty),
        .i_head              (q_head),
        .o_pop               (pop),
        .o_clearing          (clearing),
        .o_valid             (o_valid),
        .o_route             (o_route),
        .o_outer_destination (o_outer_destination),
        .o_outer_source      (o_outer_source),
        .o_table_full        (o_table_full)
    );

endmodule

[sv/mbt_front.sv]
// Front end of the binding table: classifies an incoming item into a
// table command and pushes it to the command queue. Uses mbt_pkg.
module mbt_front
    import mbt_pkg::*;
(
    input  logic        i_start,
    input  logic        i_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_lookup_address,
    input  logic [31:0] i_care_of_address,
    input  logic [15:0] i_lifetime,
    input  logic [7:0]  i_reply_code,
    input  logic [7:0]  i_ip_protocol,
    input  logic [15:0] i_udp_dest_port,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_op op;

    always_comb begin
        case (i_kind)
            KIND_REQUEST: begin
                if (i_ip_protocol == PROTO_UDP && i_udp_dest_port == PORT_REGISTRATION) begin
                    op = OP_REQ;
                end else begin
                    op = OP_DROP;
                end
            end
            KIND_REPLY: begin
                op = (i_reply_code != REPLY_ACCEPTED) ? OP_REPLY_DEL : OP_REPLY_KEEP;
            end
            KIND_PLAIN: op = OP_PLAIN;
            KIND_ENCAP: op = OP_ENCAP;
            KIND_TICK:  op = OP_TICK;
            default:    op = OP_DROP;
        endcase
    end

    assign o_push        = i_start && i_ready;
    assign o_cmd.op      = op;
    assign o_cmd.addr    = i_lookup_address;
    assign o_cmd.care_of = i_care_of_address;
    assign o_cmd.life    = i_lifetime;

endmodule

[sv/mbt_cmd_fifo.sv]
// Short command queue between the front end and the table engine.
// Uses mbt_pkg for the command type and depth.
module mbt_cmd_fifo
    import mbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);

    t_cmd                r_buf [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_buf[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[sv/mbt_engine.sv]
// Table engine: holds the binding memory and carries out one command at a time,
// walking the table for those that need it (lookup, remove, insert, lifetime countdown). Uses mbt_pkg.
module mbt_engine
    import mbt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    output logic [2:0]  o_route,
    output logic [31:0] o_outer_destination,
    output logic [31:0] o_outer_source,
    output logic        o_table_full
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_INS
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [IW-1:0] r_idx;
    logic          r_issue;
    logic          r_chk_vld;
    logic [IW-1:0] r_chk_idx;
    logic          r_chk_last;
    logic          r_found;
    logic [IW-1:0] r_match_idx;
    logic [31:0]   r_match_coa;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_out_vld;
    logic [2:0]    r_route;
    logic [31:0]   r_odst;
    logic [31:0]   r_osrc;
    logic          r_full;

    t_entry        mem [TABLE_DEPTH];
    t_entry        r_rdata;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [IW-1:0] ins_idx;
    logic          have_slot;
    logic          table_op;

    // Lowest free entry once the old binding is gone
    assign ins_idx   = (r_found && (!r_free_found || r_match_idx < r_free_idx))
                       ? r_match_idx : r_free_idx;
    assign have_slot = r_found || r_free_found;
    assign table_op  = (i_head.op == OP_REQ) || (i_head.op == OP_REPLY_DEL) ||
                       (i_head.op == OP_PLAIN) || (i_head.op == OP_ENCAP) ||
                       (i_head.op == OP_TICK);

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_SCAN: begin
                if (r_chk_vld && r_cmd.op == OP_TICK && r_rdata.valid) begin
                    mem_we              = 1'b1;
                    mem_waddr           = r_chk_idx;
                    mem_wdata.valid     = (r_rdata.remaining > 16'd1);
                    mem_wdata.home      = r_rdata.home;
                    mem_wdata.care_of   = r_rdata.care_of;
                    mem_wdata.remaining = (r_rdata.remaining > 16'd1)
                                          ? r_rdata.remaining - 16'd1 : 16'd0;
                end
            end
            S_FIN: begin
                if (r_found && (r_cmd.op == OP_REQ || r_cmd.op == OP_REPLY_DEL)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_match_idx;
                end
            end
            S_INS: begin
                mem_we              = 1'b1;
                mem_waddr           = ins_idx;
                mem_wdata.valid     = 1'b1;
                mem_wdata.home      = r_cmd.addr;
                mem_wdata.care_of   = r_cmd.care_of;
                mem_wdata.remaining = r_cmd.life;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (r_idx == IDX_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd        <= i_head;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_idx        <= '0;
                        if (table_op) begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk_vld  <= r_issue;
                    r_chk_idx  <= r_idx;
                    r_chk_last <= (r_idx == IDX_LAST);
                    if (r_issue) begin
                        if (r_idx == IDX_LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_chk_vld) begin
                        if (r_rdata.valid && r_rdata.home == r_cmd.addr && !r_found) begin
                            r_found     <= 1'b1;
                            r_match_idx <= r_chk_idx;
                            r_match_coa <= r_rdata.care_of;
                        end
                        if (!r_rdata.valid && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_chk_idx;
                        end
                        if (r_chk_last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_odst  <= '0;
                    r_osrc  <= '0;
                    r_full  <= 1'b0;
                    r_state <= S_IDLE;
                    r_out_vld <= 1'b1;
                    case (r_cmd.op)
                        OP_REQ: begin
                            r_route <= ROUTE_REQUEST;
                            if (r_cmd.life != '0) begin
                                if (have_slot) begin
                                    r_out_vld <= 1'b0;
                                    r_state   <= S_INS;
                                end else begin
                                    r_full <= 1'b1;
                                end
                            end
                        end
                        OP_REPLY_DEL, OP_REPLY_KEEP: r_route <= ROUTE_REPLY;
                        OP_PLAIN: r_route <= r_found ? ROUTE_TUNNEL : ROUTE_NO_TUNNEL;
                        OP_ENCAP: begin
                            if (r_found) begin
                                r_route <= ROUTE_REWRITTEN;
                                r_odst  <= r_match_coa;
                                r_osrc  <= r_cmd.addr;
                            end else begin
                                r_route <= ROUTE_DROPPED;
                            end
                        end
                        OP_TICK: r_route <= ROUTE_TICK;
                        default: r_route <= ROUTE_DROPPED;
                    endcase
                end
                S_INS: begin
                    r_out_vld <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_out_vld;
    assign o_route             = r_route;
    assign o_outer_destination = r_odst;
    assign o_outer_source      = r_osrc;
    assign o_table_full        = r_full;

endmodule

[tb/mobility_binding_table_core_test.sv]
// Self-checking testbench for mobility_binding_table_core.
// Depends on mbt_pkg and the core RTL. A scoreboard class predicts each route,
// and a plain task drives the start/busy command port.
`timescale 1ns / 1ps

module mobility_binding_table_core_test
    import mbt_pkg::*;
;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;   // more homes than entries, so the table can fill
    localparam int BLOCK_ITEMS = 50;
    localparam int BLOCKS      = 9;

    // One expected or observed result transfer.
    typedef struct packed {
        logic [2:0]  route;
        logic [31:0] outer_dst;
        logic [31:0] outer_src;
        logic        full;
    } t_route_result;

    // Predicts the binding table and checks each result against the oldest prediction.
    class route_scoreboard;
        logic          bind_valid[TABLE_DEPTH];
        logic [31:0]   bind_home[TABLE_DEPTH];
        logic [31:0]   bind_care_of[TABLE_DEPTH];
        logic [15:0]   bind_left[TABLE_DEPTH];
        t_route_result pending_routes[$];
        int errors, n_sent, n_checked, n_inserted, n_full, n_expired, n_tunnel, n_rewritten;

        function new();
            foreach (bind_valid[i]) bind_valid[i] = 1'b0;
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        function int find_home(logic [31:0] addr);
            foreach (bind_valid[i])
                if (bind_valid[i] && bind_home[i] == addr) return i;
            return -1;
        endfunction

        function int find_free();
            foreach (bind_valid[i])
                if (!bind_valid[i]) return i;
            return -1;
        endfunction

        // Apply one accepted command to the predicted table and queue its route.
        function void note_transfer(logic [2:0] kind, logic [31:0] addr, logic [31:0] coa,
                                    logic [15:0] life, logic [7:0] code,
                                    logic [7:0] proto, logic [15:0] port);
            t_route_result r;
            int hit;
            int slot;
            r = '{route: ROUTE_DROPPED, outer_dst: '0, outer_src: '0, full: 1'b0};
            hit = find_home(addr);
            n_sent++;
            case (kind)
                KIND_REQUEST: begin
                    if (proto == PROTO_UDP && port == PORT_REGISTRATION) begin
                        if (hit >= 0) bind_valid[hit] = 1'b0;
                        if (life != 16'd0) begin
                            slot = find_free();
                            if (slot >= 0) begin
                                bind_valid[slot]   = 1'b1;
                                bind_home[slot]    = addr;
                                bind_care_of[slot] = coa;
                                bind_left[slot]    = life;
                                n_inserted++;
                            end else begin
                                r.full = 1'b1;
                                n_full++;
                            end
                        end
                        r.route = ROUTE_REQUEST;
                    end
                end
                KIND_REPLY: begin
                    if (code != REPLY_ACCEPTED && hit >= 0) bind_valid[hit] = 1'b0;
                    r.route = ROUTE_REPLY;
                end
                KIND_PLAIN: begin
                    r.route = (hit >= 0) ? ROUTE_TUNNEL : ROUTE_NO_TUNNEL;
                    if (hit >= 0) n_tunnel++;
                end
                KIND_ENCAP: begin
                    if (hit >= 0) begin
                        r.route     = ROUTE_REWRITTEN;
                        r.outer_dst = bind_care_of[hit];
                        r.outer_src = addr;
                        n_rewritten++;
                    end
                end
                KIND_TICK: begin
                    foreach (bind_valid[i]) begin
                        if (bind_valid[i]) begin
                            if (bind_left[i] <= 16'd1) begin
                                bind_valid[i] = 1'b0;
                                n_expired++;
                            end else begin
                                bind_left[i] = bind_left[i] - 16'd1;
                            end
                        end
                    end
                    r.route = ROUTE_TICK;
                end
                default: ;
            endcase
            pending_routes.insert(pending_routes.size(), r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
                flag($sformatf("%s mismatch: expected %h, actual %h", name, exp_v, act_v));
        endfunction

        function void check_result(t_route_result act);
            t_route_result exp_r;
            if (pending_routes.size() == 0) begin
                flag($sformatf("result with nothing expected: route %0d dst %h src %h full %b",
                               act.route, act.outer_dst, act.outer_src, act.full));
                return;
            end
            exp_r = pending_routes.pop_front();
            n_checked++;
            check_field("route", 32'(exp_r.route), 32'(act.route));
            check_field("outer_destination", exp_r.outer_dst, act.outer_dst);
            check_field("outer_source", exp_r.outer_src, act.outer_src);
            check_field("table_full", 32'(exp_r.full), 32'(act.full));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_kind;
    logic [31:0] i_lookup_address;
    logic [31:0] i_care_of_address;
    logic [15:0] i_lifetime;
    logic [7:0]  i_reply_code;
    logic [7:0]  i_ip_protocol;
    logic [15:0] i_udp_dest_port;
    logic        o_valid;
    logic [2:0]  o_route;
    logic [31:0] o_outer_destination;
    logic [31:0] o_outer_source;
    logic        o_table_full;

    route_scoreboard route_sb = new();
    logic [31:0] home_pool[POOL_SIZE];

    mobility_binding_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_kind             (i_kind),
        .i_lookup_address   (i_lookup_address),
        .i_care_of_address  (i_care_of_address),
        .i_lifetime         (i_lifetime),
        .i_reply_code       (i_reply_code),
        .i_ip_protocol      (i_ip_protocol),
        .i_udp_dest_port    (i_udp_dest_port),
        .o_valid            (o_valid),
        .o_route            (o_route),
        .o_outer_destination(o_outer_destination),
        .o_outer_source     (o_outer_source),
        .o_table_full       (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Sample results with the values that stand before the edge; the receiver
    // never stalls, so every strobe is a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            route_sb.check_result('{route: o_route, outer_dst: o_outer_destination,
                                    outer_src: o_outer_source, full: o_table_full});
    end

    // Always back to back when steady; else mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap(bit steady);
        int sel;
        if (steady) return 0;
        sel = $urandom_range(99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // Small lifetimes dominate so that ticks free entries during the run.
    function automatic logic [15:0] pick_lifetime();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return 16'd0;
        if (sel < 75) return 16'($urandom_range(12, 1));
        if (sel < 80) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_address();
        if ($urandom_range(99) < 85) return home_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Present one command, hold it until busy is low at an edge, then record the
    // transfer. Keep start high across back-to-back commands; drop it only for a gap.
    task automatic transfer_item(input logic [2:0] kind, input logic [31:0] addr,
                                 input logic [31:0] coa, input logic [15:0] life,
                                 input logic [7:0] code, input logic [7:0] proto,
                                 input logic [15:0] port, input int gap_after);
        start             <= 1'b1;
        i_kind            <= kind;
        i_lookup_address  <= addr;
        i_care_of_address <= coa;
        i_lifetime        <= life;
        i_reply_code      <= code;
        i_ip_protocol     <= proto;
        i_udp_dest_port   <= port;
        do @(posedge i_clk); while (busy !== 1'b0);
        route_sb.note_transfer(kind, addr, coa, life, code, proto, port);
        if (gap_after > 0) begin
            start <= 1'b0;
            repeat (gap_after) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [31:0] coa;
        logic [15:0] life;
        logic [7:0]  code;
        logic [7:0]  proto;
        logic [15:0] port;
        int          sel;
        int          tick_pct;
        int          n_drain;
        bit          steady;

        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_kind            <= KIND_REQUEST;
        i_lookup_address  <= '0;
        i_care_of_address <= '0;
        i_lifetime        <= '0;
        i_reply_code      <= '0;
        i_ip_protocol     <= '0;
        i_udp_dest_port   <= '0;
        home_pool[0] = 32'h0000_0000;
        home_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) home_pool[i] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass after reset shows up as busy; the handshake absorbs it.

        // Directed: empty-table lookups, extreme addresses, expiry, malformed
        // requests, keep/deny replies, re-registration and deregistration.
        transfer_item(KIND_PLAIN, 32'h0, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        transfer_item(KIND_ENCAP, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        transfer_item(KIND_REQUEST, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 8'hFF,
                      PROTO_UDP, PORT_REGISTRATION, pick_gap(0));
        transfer_item(KIND_REQUEST, 32'h0, 32'hFFFF_FFFF, 16'd1, 8'h0,
                      PROTO_UDP, PORT_REGISTRATION, pick_gap(0));
        transfer_item(KIND_ENCAP, 32'h0, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        transfer_item(KIND_PLAIN, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 0);
        // Lifetime of one: the tick frees the binding of address zero.
        transfer_item(KIND_TICK, 32'h0, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        transfer_item(KIND_ENCAP, 32'h0, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        // Not a registration: wrong protocol, wrong port, both wrong.
        transfer_item(KIND_REQUEST, 32'h0, 32'h1, 16'd5, 8'h0, 8'd6, PORT_REGISTRATION, 0);
        transfer_item(KIND_REQUEST, 32'h0, 32'h1, 16'd5, 8'h0, PROTO_UDP, 16'd433, 0);
        transfer_item(KIND_REQUEST, 32'h1234_5678, 32'h1, 16'd5, 8'h0, 8'hFF, 16'hFFFF,
                      pick_gap(0));
        transfer_item(KIND_REPLY, 32'hFFFF_FFFF, 32'h0, 16'h0, REPLY_ACCEPTED, 8'h0, 16'h0, 0);
        transfer_item(KIND_ENCAP, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        // Re-registration replaces the care-of address.
        transfer_item(KIND_REQUEST, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 16'd2, 8'h0,
                      PROTO_UDP, PORT_REGISTRATION, 0);
        transfer_item(KIND_ENCAP, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 0);
        transfer_item(KIND_REPLY, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        transfer_item(KIND_PLAIN, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, 0);
        // Denied reply for an address with no binding.
        transfer_item(KIND_REPLY, 32'h0000_0001, 32'h0, 16'h0, 8'hFF, 8'h0, 16'h0, 0);
        // Zero lifetime deregisters.
        transfer_item(KIND_REQUEST, 32'h5, 32'h1, 16'd3, 8'h0, PROTO_UDP, PORT_REGISTRATION, 0);
        transfer_item(KIND_REQUEST, 32'h5, 32'h1, 16'd0, 8'h0, PROTO_UDP, PORT_REGISTRATION, 0);
        transfer_item(KIND_PLAIN, 32'h5, 32'h0, 16'h0, 8'h0, 8'h0, 16'h0, pick_gap(0));
        // Undefined kinds are dropped.
        transfer_item(3'd7, 32'h5, 32'h1, 16'd3, 8'h0, PROTO_UDP, PORT_REGISTRATION,
                      pick_gap(0));

        // Random: each block picks a rare (filling the table), medium or frequent (draining
        // it) tick rate, the first two blocks always rare; some blocks run with no gaps at all.
        for (int blk = 0; blk < BLOCKS; blk++) begin
            sel = $urandom_range(2);
            tick_pct = (blk < 2 || sel == 0) ? 2 : (sel == 1) ? 8 : 30;
            steady = ($urandom_range(3) == 0);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                addr  = pick_address();
                coa   = $urandom;
                life  = pick_lifetime();
                code  = $urandom;
                proto = $urandom;
                port  = $urandom;
                if ($urandom_range(99) < tick_pct) begin
                    kind = KIND_TICK;
                end else begin
                    sel = $urandom_range(99);
                    if (sel < 45) begin
                        kind  = KIND_REQUEST;
                        proto = PROTO_UDP;
                        port  = PORT_REGISTRATION;
                    end else if (sel < 50) begin
                        // Broken registration: one or both of protocol and port wrong.
                        kind = KIND_REQUEST;
                        case ($urandom_range(2))
                            0: begin
                                if (proto == PROTO_UDP) proto = ~proto;
                                port = PORT_REGISTRATION;
                            end
                            1: begin
                                proto = PROTO_UDP;
                                if (port == PORT_REGISTRATION) port = ~port;
                            end
                            default: ;
                        endcase
                    end else if (sel < 63) begin
                        kind = KIND_REPLY;
                        if ($urandom_range(1) == 0) code = REPLY_ACCEPTED;
                    end else if (sel < 78) begin
                        kind = KIND_PLAIN;
                    end else if (sel < 96) begin
                        kind = KIND_ENCAP;
                    end else begin
                        kind = 3'($urandom_range(7, 5));
                    end
                end
                transfer_item(kind, addr, coa, life, code, proto, port, pick_gap(steady));
            end
        end
        start <= 1'b0;

        // Wait for every predicted route, then allow a further margin for strays.
        n_drain = 0;
        while (route_sb.pending_routes.size() != 0 && n_drain < 400) begin
            @(posedge i_clk);
            n_drain++;
        end
        repeat (2 * TABLE_DEPTH + 8) @(posedge i_clk);
        if (route_sb.pending_routes.size() != 0)
            route_sb.flag($sformatf("%0d expected results never arrived",
                                    route_sb.pending_routes.size()));

        $display("Run covered %0d commands, %0d results checked: %0d inserts, %0d %s",
                 route_sb.n_sent, route_sb.n_checked, route_sb.n_inserted, route_sb.n_full,
                 "full-table refusals,");
        $display("%0d expirations, %0d tunnel hits, %0d rewrites; %0d errors.",
                 route_sb.n_expired, route_sb.n_tunnel, route_sb.n_rewritten, route_sb.errors);
        if (route_sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
